### rtl/csc_pkg.sv
`timescale 1ns / 1ps

package csc_pkg;

  localparam int DEFAULT_MAX_LEN    = 1024;
  localparam int DEFAULT_ELEM_WIDTH = 16;

  localparam int SCORE_W  = 17;
  localparam int STATUS_W = 2;
  localparam int Q_BITS   = 17;

  localparam logic [SCORE_W-1:0] SCORE_ONE  = SCORE_W'(65536);
  localparam logic [SCORE_W-1:0] SCORE_ZERO = '0;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_ZERO_NORM = 2'd1,
    ST_TOO_LONG  = 2'd2
  } status_t;

endpackage

### rtl/cosine_similarity_clamped_unit.sv
`timescale 1ns / 1ps

// Element beat: accept, then multiply and accumulate for p*p, r*r, p*r in turn on one
// shared multiplier. A beat past MAX_LEN elements is accepted but not multiplied or accumulated.
// Closing beat: unless the checks settle the score early, one shared subtractor runs RW root
// steps per norm and 17 divide steps, RW = ceil(min(64, 2*ELEM_WIDTH + clog2(MAX_LEN+1))/2) (22 default).
// One result register decouples the output side; a held result stalls only the next close.
// rst_n (synchronous) clears sequencer, accumulators, element count, flags and out_valid.
module cosine_similarity_clamped_unit
  import csc_pkg::*;
#(
  parameter int MAX_LEN    = DEFAULT_MAX_LEN,
  parameter int ELEM_WIDTH = DEFAULT_ELEM_WIDTH
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [ELEM_WIDTH-1:0] in_probe_element,
  input  logic signed [ELEM_WIDTH-1:0] in_reference_element,
  input  logic                         in_last_element,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [SCORE_W-1:0]           out_score,
  output logic [STATUS_W-1:0]          out_status
);

  localparam int EW   = ELEM_WIDTH;
  localparam int CW   = $clog2(MAX_LEN + 1);
  localparam int AW   = (2 * EW + CW > 64) ? 64 : 2 * EW + CW;
  localparam int RW   = (AW + 1) / 2;
  localparam int NW   = 2 * RW;
  localparam int SW   = NW + 1;
  localparam int MW   = (EW > RW) ? EW : RW;
  localparam int PW   = 2 * MW + 2;
  localparam int DCW  = $clog2(Q_BITS);

  localparam logic [CW-1:0]  COUNT_LIMIT = CW'(MAX_LEN);
  localparam logic [NW-1:0]  BIT_INIT    = NW'(1) << (NW - 2);
  localparam logic [NW-1:0]  BIT_LAST    = NW'(1);
  localparam logic [DCW-1:0] DIV_LAST    = DCW'(Q_BITS - 1);

  localparam logic [1:0] MAC_PP = 2'd0;
  localparam logic [1:0] MAC_RR = 2'd1;
  localparam logic [1:0] MAC_PR = 2'd2;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_MUL   = 9'b000000010,
    S_ACC   = 9'b000000100,
    S_CHECK = 9'b000001000,
    S_SQRT  = 9'b000010000,
    S_DEN   = 9'b000100000,
    S_CMP   = 9'b001000000,
    S_DIV   = 9'b010000000,
    S_DONE  = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;

  logic signed [EW-1:0] p_r, p_nxt;
  logic signed [EW-1:0] q_el_r, q_el_nxt;
  logic                 last_r, last_nxt;
  logic [1:0]           mac_sel_r, mac_sel_nxt;

  logic [AW-1:0] dot_r, dot_nxt;
  logic [AW-1:0] pn_r, pn_nxt;
  logic [AW-1:0] rn_r, rn_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          ovf_r, ovf_nxt;

  logic signed [PW-1:0] prod_r, prod_nxt;
  logic signed [MW:0]   mult_a, mult_b;

  logic [NW-1:0] sq_n_r, sq_n_nxt;
  logic [NW-1:0] sq_root_r, sq_root_nxt;
  logic [NW-1:0] sq_bit_r, sq_bit_nxt;
  logic          sq_sel_r, sq_sel_nxt;
  logic [RW-1:0] root_p_r, root_p_nxt;
  logic [RW-1:0] root_q_r, root_q_nxt;
  logic [NW:0]   sq_add;

  logic [NW-1:0]     rem_r, rem_nxt;
  logic [Q_BITS-1:0] quo_r, quo_nxt;
  logic [DCW-1:0]    div_cnt_r, div_cnt_nxt;

  logic [SW-1:0] sub_a, sub_b;
  logic [SW:0]   sub_diff;
  logic          sub_borrow;

  logic [SCORE_W-1:0]  score_r, score_nxt;
  logic [STATUS_W-1:0] status_r, status_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic [SCORE_W-1:0]  out_score_r, out_score_nxt;
  logic [STATUS_W-1:0] out_status_r, out_status_nxt;

  logic          in_fire;
  logic          out_free;
  logic [NW-1:0] den;

  assign in_stall   = (state_r != S_IDLE);
  assign in_fire    = in_valid && !in_stall;
  assign out_free   = !out_valid_r || !out_stall;
  assign out_valid  = out_valid_r;
  assign out_score  = out_score_r;
  assign out_status = out_status_r;
  assign den        = prod_r[NW-1:0];

  always_comb begin
    mult_a = (MW + 1)'(p_r);
    mult_b = (MW + 1)'(p_r);
    if (state_r == S_DEN) begin
      mult_a = (MW + 1)'(root_p_r);
      mult_b = (MW + 1)'(root_q_r);
    end else begin
      case (mac_sel_r)
        MAC_PP: begin
          mult_a = (MW + 1)'(p_r);
          mult_b = (MW + 1)'(p_r);
        end
        MAC_RR: begin
          mult_a = (MW + 1)'(q_el_r);
          mult_b = (MW + 1)'(q_el_r);
        end
        default: begin
          mult_a = (MW + 1)'(p_r);
          mult_b = (MW + 1)'(q_el_r);
        end
      endcase
    end
    prod_nxt = mult_a * mult_b;
  end

  assign sq_add = {1'b0, sq_root_r} + {1'b0, sq_bit_r};

  always_comb begin
    sub_a = SW'(sq_n_r);
    sub_b = SW'(sq_add);
    if (state_r == S_CMP) begin
      sub_a = SW'(dot_r);
      sub_b = SW'(den);
    end else if (state_r == S_DIV) begin
      sub_a = {rem_r, 1'b0};
      sub_b = SW'(den);
    end
    sub_diff   = {1'b0, sub_a} - {1'b0, sub_b};
    sub_borrow = sub_diff[SW];
  end

  always_comb begin
    state_nxt      = state_r;
    p_nxt          = p_r;
    q_el_nxt       = q_el_r;
    last_nxt       = last_r;
    mac_sel_nxt    = mac_sel_r;
    dot_nxt        = dot_r;
    pn_nxt         = pn_r;
    rn_nxt         = rn_r;
    count_nxt      = count_r;
    ovf_nxt        = ovf_r;
    sq_n_nxt       = sq_n_r;
    sq_root_nxt    = sq_root_r;
    sq_bit_nxt     = sq_bit_r;
    sq_sel_nxt     = sq_sel_r;
    root_p_nxt     = root_p_r;
    root_q_nxt     = root_q_r;
    rem_nxt        = rem_r;
    quo_nxt        = quo_r;
    div_cnt_nxt    = div_cnt_r;
    score_nxt      = score_r;
    status_nxt     = status_r;
    out_valid_nxt  = out_valid_r;
    out_score_nxt  = out_score_r;
    out_status_nxt = out_status_r;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          p_nxt       = in_probe_element;
          q_el_nxt    = in_reference_element;
          last_nxt    = in_last_element;
          mac_sel_nxt = MAC_PP;
          if (count_r >= COUNT_LIMIT) begin
            ovf_nxt   = 1'b1;
            state_nxt = in_last_element ? S_CHECK : S_IDLE;
          end else begin
            state_nxt = S_MUL;
          end
        end
      end
      S_MUL: begin
        state_nxt = S_ACC;
      end
      S_ACC: begin
        case (mac_sel_r)
          MAC_PP: begin
            pn_nxt      = pn_r + prod_r[AW-1:0];
            mac_sel_nxt = MAC_RR;
            state_nxt   = S_MUL;
          end
          MAC_RR: begin
            rn_nxt      = rn_r + prod_r[AW-1:0];
            mac_sel_nxt = MAC_PR;
            state_nxt   = S_MUL;
          end
          default: begin
            dot_nxt     = dot_r + prod_r[AW-1:0];
            count_nxt   = count_r + CW'(1);
            mac_sel_nxt = MAC_PP;
            state_nxt   = last_r ? S_CHECK : S_IDLE;
          end
        endcase
      end
      S_CHECK: begin
        score_nxt = SCORE_ZERO;
        if (ovf_r) begin
          status_nxt = ST_TOO_LONG;
          state_nxt  = S_DONE;
        end else if (pn_r == '0 || rn_r == '0) begin
          status_nxt = ST_ZERO_NORM;
          state_nxt  = S_DONE;
        end else if (dot_r[AW-1] || dot_r == '0) begin
          status_nxt = ST_OK;
          state_nxt  = S_DONE;
        end else begin
          status_nxt  = ST_OK;
          sq_n_nxt    = NW'(pn_r);
          sq_root_nxt = '0;
          sq_bit_nxt  = BIT_INIT;
          sq_sel_nxt  = 1'b0;
          state_nxt   = S_SQRT;
        end
      end
      S_SQRT: begin
        if (!sub_borrow) begin
          sq_n_nxt    = sub_diff[NW-1:0];
          sq_root_nxt = (sq_root_r >> 1) + sq_bit_r;
        end else begin
          sq_root_nxt = sq_root_r >> 1;
        end
        sq_bit_nxt = sq_bit_r >> 2;
        if (sq_bit_r == BIT_LAST) begin
          if (!sq_sel_r) begin
            root_p_nxt  = sq_root_nxt[RW-1:0];
            sq_n_nxt    = NW'(rn_r);
            sq_root_nxt = '0;
            sq_bit_nxt  = BIT_INIT;
            sq_sel_nxt  = 1'b1;
          end else begin
            root_q_nxt = sq_root_nxt[RW-1:0];
            state_nxt  = S_DEN;
          end
        end
      end
      S_DEN: begin
        state_nxt = S_CMP;
      end
      S_CMP: begin
        if (!sub_borrow) begin
          score_nxt = SCORE_ONE;
          state_nxt = S_DONE;
        end else begin
          rem_nxt     = NW'(dot_r);
          quo_nxt     = '0;
          div_cnt_nxt = '0;
          state_nxt   = S_DIV;
        end
      end
      S_DIV: begin
        if (!sub_borrow) begin
          rem_nxt = sub_diff[NW-1:0];
        end else begin
          rem_nxt = {rem_r[NW-2:0], 1'b0};
        end
        quo_nxt     = {quo_r[Q_BITS-2:0], !sub_borrow};
        div_cnt_nxt = div_cnt_r + DCW'(1);
        if (div_cnt_r == DIV_LAST) begin
          score_nxt = SCORE_W'(quo_nxt >> 1) + SCORE_W'(quo_nxt[0]);
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_score_nxt  = score_r;
          out_status_nxt = status_r;
          dot_nxt        = '0;
          pn_nxt         = '0;
          rn_nxt         = '0;
          count_nxt      = '0;
          ovf_nxt        = 1'b0;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      mac_sel_r   <= MAC_PP;
      dot_r       <= '0;
      pn_r        <= '0;
      rn_r        <= '0;
      count_r     <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      mac_sel_r   <= mac_sel_nxt;
      dot_r       <= dot_nxt;
      pn_r        <= pn_nxt;
      rn_r        <= rn_nxt;
      count_r     <= count_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    p_r          <= p_nxt;
    q_el_r       <= q_el_nxt;
    last_r       <= last_nxt;
    if (state_r == S_MUL || state_r == S_DEN) begin
      prod_r <= prod_nxt;
    end
    sq_n_r       <= sq_n_nxt;
    sq_root_r    <= sq_root_nxt;
    sq_bit_r     <= sq_bit_nxt;
    sq_sel_r     <= sq_sel_nxt;
    root_p_r     <= root_p_nxt;
    root_q_r     <= root_q_nxt;
    rem_r        <= rem_nxt;
    quo_r        <= quo_nxt;
    div_cnt_r    <= div_cnt_nxt;
    score_r      <= score_nxt;
    status_r     <= status_nxt;
    out_score_r  <= out_score_nxt;
    out_status_r <= out_status_nxt;
  end

endmodule
